// File: rtl/rfpwd_pkg.sv
// Shared constants, register codes and types of the pulse-width frame decoder.
`default_nettype none

package rfpwd_pkg;

   // Field widths of one pulse transaction and one result transaction.
   localparam int HIGH_W   = 16;
   localparam int LOW_W    = 16;
   localparam int PERIOD_W = 17;
   localparam int BYTE_W   = 8;
   localparam int BYTES_W  = 64;

   // Frame geometry.
   localparam int FRAME_BYTES_DEF = 8;
   localparam int BITS_PER_BYTE   = 8;
   localparam int BIT_IDX_W       = $clog2(BITS_PER_BYTE);

   // Configuration port geometry: seven 32-bit registers at byte address 4*i.
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;

   // Register reset values.
   localparam logic [LOW_W-1:0]    GLITCH_LOW_MAX_RST  = LOW_W'(2);
   localparam logic [PERIOD_W-1:0] BIT_PERIOD_MIN_RST  = PERIOD_W'(4);
   localparam logic [PERIOD_W-1:0] BIT_PERIOD_MAX_RST  = PERIOD_W'(9);
   localparam logic [PERIOD_W-1:0] HEAD_PERIOD_MIN_RST = PERIOD_W'(20);
   localparam logic [PERIOD_W-1:0] HEAD_PERIOD_MAX_RST = PERIOD_W'(43);
   localparam logic [HIGH_W-1:0]   HEAD_HIGH_MIN_RST   = HIGH_W'(3);
   localparam logic [BYTE_W-1:0]   FRAME_LEAD_BYTE_RST = BYTE_W'(0);

   // Register index codes (word address).
   typedef enum logic [2:0] {
      REG_GLITCH_LOW_MAX  = 3'd0,
      REG_BIT_PERIOD_MIN  = 3'd1,
      REG_BIT_PERIOD_MAX  = 3'd2,
      REG_HEAD_PERIOD_MIN = 3'd3,
      REG_HEAD_PERIOD_MAX = 3'd4,
      REG_HEAD_HIGH_MIN   = 3'd5,
      REG_FRAME_LEAD_BYTE = 3'd6
   } reg_index_type;

   // Current configuration handed from the register file to the decoder.
   typedef struct packed {
      logic [LOW_W-1:0]    glitch_low_max;
      logic [PERIOD_W-1:0] bit_period_min;
      logic [PERIOD_W-1:0] bit_period_max;
      logic [PERIOD_W-1:0] head_period_min;
      logic [PERIOD_W-1:0] head_period_max;
      logic [HIGH_W-1:0]   head_high_min;
      logic [BYTE_W-1:0]   frame_lead_byte;
   } cfg_type;

endpackage

`default_nettype wire

// File: rtl/rfpwd_channels.sv
// Valid/ready channel interfaces for pulse transactions and result transactions.
`default_nettype none

interface rfpwd_req_if;
   logic                          valid;
   logic                          ready;
   logic [rfpwd_pkg::HIGH_W-1:0]  high_count;
   logic [rfpwd_pkg::LOW_W-1:0]   low_count;

   modport source (output valid, output high_count, output low_count, input ready);
   modport sink   (input valid, input high_count, input low_count, output ready);
endinterface

interface rfpwd_rsp_if;
   logic                          valid;
   logic                          ready;
   logic                          activity;
   logic                          frame_done;
   logic                          frame_ok;
   logic [rfpwd_pkg::BYTES_W-1:0] frame_bytes;
   logic                          in_frame;

   modport source (output valid, output activity, output frame_done, output frame_ok,
                   output frame_bytes, output in_frame, input ready);
   modport sink   (input valid, input activity, input frame_done, input frame_ok,
                   input frame_bytes, input in_frame, output ready);
endinterface

`default_nettype wire

// File: rtl/rf_pulse_width_frame_decoder.sv
// Top level of the pulse-width frame decoder: pulse register, frame state and result register.
//
//   channel  direction  handshake     payload
//   req_bus  in         valid/ready   high_count[15:0], low_count[15:0]
//   rsp_bus  out        valid/ready   activity, frame_done, frame_ok, frame_bytes[63:0], in_frame
//   csr_*    in/out     APB           seven timing and lead-byte registers, 4-byte stride
//
// One pulse transaction is accepted per cycle unless a stalled result keeps the pulse register full;
// its result is registered with the window compare, shift and checksum logic between the two registers.
// Exactly one result transaction follows every pulse transaction, in order.
// Synchronous reset clears the frame state and both valid flags; the byte store is not cleared.
// A stalled result holds the pipeline; the pulse register keeps one more transaction meanwhile.
`default_nettype none

module rf_pulse_width_frame_decoder #(
   parameter int FRAME_BYTES = rfpwd_pkg::FRAME_BYTES_DEF
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   rfpwd_req_if.sink                             req_bus,
   rfpwd_rsp_if.source                           rsp_bus,
   input  wire logic                             csr_psel,
   input  wire logic                             csr_penable,
   input  wire logic                             csr_pwrite,
   input  wire logic [rfpwd_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [rfpwd_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic      [rfpwd_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                                  csr_pready
);
   import rfpwd_pkg::*;

   localparam int                   IDX_W     = $clog2(FRAME_BYTES);
   localparam logic [IDX_W-1:0]     LAST_BYTE = IDX_W'(FRAME_BYTES - 1);
   localparam logic [BIT_IDX_W-1:0] LAST_BIT  = BIT_IDX_W'(BITS_PER_BYTE - 1);

   cfg_type cfg;

   // Pulse register.
   logic                  pulse_valid_ff, pulse_valid_in;
   logic [HIGH_W-1:0]     high_ff;
   logic [LOW_W-1:0]      low_ff;
   logic                  req_take;
   logic                  advance;

   // Frame state and byte store.
   logic                  header_seen_ff, header_seen_in;
   logic [BIT_IDX_W-1:0]  bit_index_ff, bit_index_in;
   logic [IDX_W-1:0]      byte_index_ff, byte_index_in;
   logic [BYTE_W-1:0]     store_ff [FRAME_BYTES];
   logic                  store_we;
   logic [BYTE_W-1:0]     shifted_byte;

   // Result register.
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  activity_ff, activity_in;
   logic                  done_ff, done_in;
   logic                  ok_ff, ok_in;
   logic [BYTES_W-1:0]    bytes_ff, bytes_in;

   // Decode terms.
   logic [PERIOD_W-1:0]   period;
   logic                  in_head;
   logic                  in_bit;
   logic                  long_high;
   logic                  bit_value;
   logic [BYTE_W-1:0]     frame_view [FRAME_BYTES];
   logic [BYTE_W-1:0]     checksum;

   rfpwd_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // Handshake: a pulse moves on when the result register is free or being emptied.
   assign advance        = pulse_valid_ff & (~rsp_valid_ff | rsp_bus.ready);
   assign req_bus.ready  = ~pulse_valid_ff | advance;
   assign req_take       = req_bus.valid & req_bus.ready;
   assign pulse_valid_in = req_take ? 1'b1 : (advance ? 1'b0 : pulse_valid_ff);
   assign rsp_valid_in   = advance ? 1'b1 : (rsp_bus.ready ? 1'b0 : rsp_valid_ff);

   // Period classification at full width.
   assign period    = {1'b0, high_ff} + {1'b0, low_ff};
   assign in_head   = (period >= cfg.head_period_min) & (period <= cfg.head_period_max);
   assign in_bit    = (period >= cfg.bit_period_min) & (period <= cfg.bit_period_max);
   assign long_high = high_ff >= cfg.head_high_min;
   assign bit_value = high_ff > low_ff;

   assign shifted_byte = {store_ff[byte_index_ff][BYTE_W-2:0], bit_value};

   // Frame contents as they stand after this bit, plus the checksum of the inner bytes.
   always_comb begin
      checksum = '0;
      for (int i = 0; i < FRAME_BYTES; i++) begin
         frame_view[i] = (IDX_W'(i) == byte_index_ff) ? shifted_byte : store_ff[i];
      end
      for (int i = 1; i < FRAME_BYTES - 1; i++) begin
         checksum = checksum + store_ff[i];
      end
   end

   // Frame state machine step for the pulse in the pulse register.
   always_comb begin
      header_seen_in = header_seen_ff;
      bit_index_in   = bit_index_ff;
      byte_index_in  = byte_index_ff;
      store_we       = 1'b0;
      activity_in    = 1'b0;
      done_in        = 1'b0;
      ok_in          = 1'b0;
      bytes_in       = '0;
      if (!header_seen_ff) begin
         // Outside a frame: the header window wins over the bit window.
         if (low_ff > cfg.glitch_low_max) begin
            if (in_head) begin
               activity_in = 1'b1;
               if (long_high) begin
                  header_seen_in = 1'b1;
                  bit_index_in   = '0;
                  byte_index_in  = '0;
               end
            end else if (in_bit) begin
               activity_in = 1'b1;
            end
         end
      end else if (period >= cfg.bit_period_min) begin
         if (in_bit) begin
            activity_in  = 1'b1;
            store_we     = 1'b1;
            bit_index_in = bit_index_ff + 1'b1;
            if (bit_index_ff == LAST_BIT) begin
               if (byte_index_ff == LAST_BYTE) begin
                  // Last bit of the last byte: emit the frame and leave it.
                  done_in = 1'b1;
                  ok_in   = (frame_view[0] == cfg.frame_lead_byte) & (shifted_byte == checksum);
                  for (int i = 0; i < FRAME_BYTES; i++) begin
                     bytes_in[BYTES_W-1-BYTE_W*i -: BYTE_W] = frame_view[i];
                  end
                  header_seen_in = 1'b0;
                  byte_index_in  = '0;
               end else begin
                  byte_index_in = byte_index_ff + 1'b1;
               end
            end
         end else if (in_head) begin
            // A fresh header restarts the frame; a weak one aborts it.
            activity_in    = 1'b1;
            header_seen_in = long_high;
            bit_index_in   = '0;
            byte_index_in  = '0;
         end else begin
            header_seen_in = 1'b0;
            bit_index_in   = '0;
            byte_index_in  = '0;
         end
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         pulse_valid_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         header_seen_ff <= 1'b0;
         bit_index_ff   <= '0;
         byte_index_ff  <= '0;
      end else begin
         pulse_valid_ff <= pulse_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
         if (advance) begin
            header_seen_ff <= header_seen_in;
            bit_index_ff   <= bit_index_in;
            byte_index_ff  <= byte_index_in;
         end
      end
   end

   // Payload registers: pulse, byte store and result.
   always_ff @(posedge clock) begin
      if (req_take) begin
         high_ff <= req_bus.high_count;
         low_ff  <= req_bus.low_count;
      end
      if (advance && store_we) begin
         store_ff[byte_index_ff] <= shifted_byte;
      end
      if (advance) begin
         activity_ff <= activity_in;
         done_ff     <= done_in;
         ok_ff       <= ok_in;
         bytes_ff    <= bytes_in;
      end
   end

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.activity    = activity_ff;
   assign rsp_bus.frame_done  = done_ff;
   assign rsp_bus.frame_ok    = ok_ff;
   assign rsp_bus.frame_bytes = bytes_ff;
   assign rsp_bus.in_frame    = header_seen_ff;

endmodule

`default_nettype wire

// File: rtl/rfpwd_csr.sv
// APB-style register file holding the decoder's timing windows and lead byte.
`default_nettype none

module rfpwd_csr (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             csr_psel,
   input  wire logic                             csr_penable,
   input  wire logic                             csr_pwrite,
   input  wire logic [rfpwd_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [rfpwd_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic      [rfpwd_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                                  csr_pready,
   output rfpwd_pkg::cfg_type                    cfg
);
   import rfpwd_pkg::*;

   cfg_type       cfg_ff;
   cfg_type       cfg_in;
   reg_index_type reg_index;
   logic          write_en;

   assign reg_index  = reg_index_type'(csr_paddr[CSR_ADDR_W-1:2]);
   assign write_en   = csr_psel & csr_penable & csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   // Register write decode; addresses past the list are ignored.
   always_comb begin
      cfg_in = cfg_ff;
      if (write_en) begin
         unique case (reg_index)
            REG_GLITCH_LOW_MAX:  cfg_in.glitch_low_max  = csr_pwdata[LOW_W-1:0];
            REG_BIT_PERIOD_MIN:  cfg_in.bit_period_min  = csr_pwdata[PERIOD_W-1:0];
            REG_BIT_PERIOD_MAX:  cfg_in.bit_period_max  = csr_pwdata[PERIOD_W-1:0];
            REG_HEAD_PERIOD_MIN: cfg_in.head_period_min = csr_pwdata[PERIOD_W-1:0];
            REG_HEAD_PERIOD_MAX: cfg_in.head_period_max = csr_pwdata[PERIOD_W-1:0];
            REG_HEAD_HIGH_MIN:   cfg_in.head_high_min   = csr_pwdata[HIGH_W-1:0];
            REG_FRAME_LEAD_BYTE: cfg_in.frame_lead_byte = csr_pwdata[BYTE_W-1:0];
            default: ;
         endcase
      end
   end

   // Read-back multiplexer.
   always_comb begin
      unique case (reg_index)
         REG_GLITCH_LOW_MAX:  csr_prdata = CSR_DATA_W'(cfg_ff.glitch_low_max);
         REG_BIT_PERIOD_MIN:  csr_prdata = CSR_DATA_W'(cfg_ff.bit_period_min);
         REG_BIT_PERIOD_MAX:  csr_prdata = CSR_DATA_W'(cfg_ff.bit_period_max);
         REG_HEAD_PERIOD_MIN: csr_prdata = CSR_DATA_W'(cfg_ff.head_period_min);
         REG_HEAD_PERIOD_MAX: csr_prdata = CSR_DATA_W'(cfg_ff.head_period_max);
         REG_HEAD_HIGH_MIN:   csr_prdata = CSR_DATA_W'(cfg_ff.head_high_min);
         REG_FRAME_LEAD_BYTE: csr_prdata = CSR_DATA_W'(cfg_ff.frame_lead_byte);
         default:             csr_prdata = '0;
      endcase
   end

   // Register storage with reset values.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.glitch_low_max  <= GLITCH_LOW_MAX_RST;
         cfg_ff.bit_period_min  <= BIT_PERIOD_MIN_RST;
         cfg_ff.bit_period_max  <= BIT_PERIOD_MAX_RST;
         cfg_ff.head_period_min <= HEAD_PERIOD_MIN_RST;
         cfg_ff.head_period_max <= HEAD_PERIOD_MAX_RST;
         cfg_ff.head_high_min   <= HEAD_HIGH_MIN_RST;
         cfg_ff.frame_lead_byte <= FRAME_LEAD_BYTE_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire
